// ===== src/obsq_pkg.sv =====
// Shared types and constants of the obstacle bypass sequencer.
// No dependencies; obsq_step and the sequencer core import this package.
package obsq_pkg;

    // Maneuver phase codes
    localparam logic [2:0] PH_NORMAL  = 3'd0;
    localparam logic [2:0] PH_CENTER  = 3'd1;
    localparam logic [2:0] PH_OUT     = 3'd2;
    localparam logic [2:0] PH_ADV_OUT = 3'd3;
    localparam logic [2:0] PH_IN      = 3'd4;
    localparam logic [2:0] PH_SIDE    = 3'd5;
    localparam logic [2:0] PH_SEARCH  = 3'd6;
    localparam logic [2:0] PH_REJOIN  = 3'd7;

    // Motor command kinds
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_STOP   = 2'd1;
    localparam logic [1:0] CMD_MOVE   = 2'd2;
    localparam logic [1:0] CMD_FOLLOW = 2'd3;

    // Fixed speeds and phase durations in ms
    localparam logic [9:0]  FOLLOW_SPEED   = 10'd300;
    localparam logic [31:0] T_STEER_OUT    = 32'd600;
    localparam logic [31:0] T_ADVANCE_OUT  = 32'd800;
    localparam logic [31:0] T_STEER_IN     = 32'd700;
    localparam logic [31:0] T_ADVANCE_SIDE = 32'd1200;
    localparam logic [31:0] T_REJOIN       = 32'd500;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DRIVE_SPEED    = 3'd0;
    localparam logic [2:0] REG_STEER_AMOUNT   = 3'd1;
    localparam logic [2:0] REG_SEARCH_STEER   = 3'd2;
    localparam logic [2:0] REG_CENTER_TOL     = 3'd3;
    localparam logic [2:0] REG_SEARCH_WINDOW  = 3'd4;
    localparam logic [2:0] REG_REJOIN_TOL     = 3'd5;
    localparam logic [2:0] REG_CENTER_TIMEOUT = 3'd6;
    localparam logic [2:0] REG_SEARCH_TIMEOUT = 3'd7;

    typedef struct packed {
        logic [9:0]  drive_speed_set;
        logic [10:0] steer_amount;
        logic [10:0] search_steer;
        logic [10:0] center_tolerance;
        logic [10:0] search_window;
        logic [10:0] rejoin_tolerance;
        logic [15:0] center_timeout_ms;
        logic [15:0] search_timeout_ms;
    } obsq_cfg_t;

    typedef struct packed {
        logic [1:0]         command_kind;
        logic [9:0]         speed;
        logic signed [11:0] steering;
        logic               clear_pid;
        logic               maneuver_done;
        logic [2:0]         phase;
    } obsq_result_t;

endpackage

// ===== src/obsq_sensor_if.sv =====
// Input channel of the sequencer: one control call per transfer.
// Standalone interface; no package dependency.
interface obsq_sensor_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic signed [11:0] bar_pos;

    modport source (output valid, output now_ms, output bar_pos, input ready);
    modport sink   (input valid, input now_ms, input bar_pos, output ready);
endinterface

// ===== src/obsq_drive_if.sv =====
// Output channel of the sequencer: one motor command result per transfer.
// Standalone interface; no package dependency.
interface obsq_drive_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command_kind;
    logic [9:0]         speed;
    logic signed [11:0] steering;
    logic               clear_pid;
    logic               maneuver_done;
    logic [2:0]         phase;

    modport source (output valid, output command_kind, output speed, output steering,
                    output clear_pid, output maneuver_done, output phase, input ready);
    modport sink   (input valid, input command_kind, input speed, input steering,
                    input clear_pid, input maneuver_done, input phase, output ready);
endinterface

// ===== src/obsq_step.sv =====
// Next-phase and motor command logic for one control call.
// Depends on obsq_pkg for phase codes, command kinds and the config struct.
module obsq_step (
    input  obsq_pkg::obsq_cfg_t    cfg,
    input  logic [2:0]             phase_cur,
    input  logic [31:0]            start_ms,
    input  logic [31:0]            now_ms,
    input  logic signed [11:0]     bar_pos,
    output obsq_pkg::obsq_result_t result,
    output logic                   start_load
);
    import obsq_pkg::*;

    logic [31:0]        elapsed;
    logic signed [12:0] pos_ext;
    logic signed [12:0] mag_ext;
    logic [11:0]        mag;
    logic signed [12:0] window;
    logic signed [11:0] steer_pos;
    logic signed [11:0] steer_neg;
    logic signed [11:0] search_neg;
    logic               line_found;
    logic [2:0]         phase_nxt;

    // Elapsed time wraps modulo 2^32
    assign elapsed = now_ms - start_ms;

    // Line offset magnitude; 2048 still fits unsigned 12 bits
    assign pos_ext = {bar_pos[11], bar_pos};
    assign mag_ext = bar_pos[11] ? -pos_ext : pos_ext;
    assign mag     = mag_ext[11:0];

    assign window     = $signed({2'b00, cfg.search_window});
    assign line_found = (pos_ext > -window) && (pos_ext < window);

    assign steer_pos  = $signed({1'b0, cfg.steer_amount});
    assign steer_neg  = -steer_pos;
    assign search_neg = -$signed({1'b0, cfg.search_steer});

    // Step the maneuver and pick the last command of the call
    always_comb
    begin
        result.command_kind  = CMD_NONE;
        result.speed         = '0;
        result.steering      = '0;
        result.clear_pid     = 1'b0;
        result.maneuver_done = 1'b0;
        phase_nxt            = phase_cur;
        case (phase_cur)
            PH_NORMAL:
            begin
                result.command_kind = CMD_STOP;
                phase_nxt           = PH_CENTER;
            end
            PH_CENTER:
            begin
                if ((mag > {1'b0, cfg.center_tolerance}) &&
                    !(elapsed > {16'd0, cfg.center_timeout_ms}))
                begin
                    result.command_kind = CMD_FOLLOW;
                    result.speed        = FOLLOW_SPEED;
                end
                else
                begin
                    result.command_kind = CMD_MOVE;
                    result.speed        = cfg.drive_speed_set;
                    result.steering     = steer_pos;
                    phase_nxt           = PH_OUT;
                end
            end
            PH_OUT:
            begin
                result.command_kind = CMD_MOVE;
                result.speed        = cfg.drive_speed_set;
                result.steering     = steer_pos;
                if (elapsed >= T_STEER_OUT)
                begin
                    result.steering = '0;
                    phase_nxt       = PH_ADV_OUT;
                end
            end
            PH_ADV_OUT:
            begin
                result.command_kind = CMD_MOVE;
                result.speed        = cfg.drive_speed_set;
                if (elapsed >= T_ADVANCE_OUT)
                begin
                    result.steering = steer_neg;
                    phase_nxt       = PH_IN;
                end
            end
            PH_IN:
            begin
                result.command_kind = CMD_MOVE;
                result.speed        = cfg.drive_speed_set;
                result.steering     = steer_neg;
                if (elapsed >= T_STEER_IN)
                begin
                    result.steering = '0;
                    phase_nxt       = PH_SIDE;
                end
            end
            PH_SIDE:
            begin
                result.command_kind = CMD_MOVE;
                result.speed        = cfg.drive_speed_set;
                if (elapsed >= T_ADVANCE_SIDE)
                begin
                    result.steering = search_neg;
                    phase_nxt       = PH_SEARCH;
                end
            end
            PH_SEARCH:
            begin
                result.command_kind = CMD_MOVE;
                result.speed        = cfg.drive_speed_set;
                result.steering     = search_neg;
                if (line_found)
                begin
                    result.steering = steer_pos;
                    phase_nxt       = PH_REJOIN;
                end
                // Timeout wins the phase but keeps the realign command
                if (elapsed > {16'd0, cfg.search_timeout_ms})
                begin
                    phase_nxt            = PH_NORMAL;
                    result.clear_pid     = 1'b1;
                    result.maneuver_done = 1'b1;
                end
            end
            default:
            begin
                // Rejoin: no motor command, wait for the line or the timeout
                if ((mag < {1'b0, cfg.rejoin_tolerance}) || (elapsed > T_REJOIN))
                begin
                    phase_nxt            = PH_NORMAL;
                    result.clear_pid     = 1'b1;
                    result.maneuver_done = 1'b1;
                end
            end
        endcase
        result.phase = phase_nxt;
    end

    // Restart the phase timer on any change except a return to normal
    assign start_load = (phase_nxt != phase_cur) && (phase_nxt != PH_NORMAL);

endmodule

// ===== src/obstacle_bypass_sequencer_core.sv =====
// Top level of the obstacle bypass sequencer: channels, registers, phase state.
// Depends on obsq_pkg, obsq_sensor_if, obsq_drive_if and obsq_step.
//
// Usage:
//   sensor carries one control call per transfer (now_ms, bar_pos). drive
//   returns exactly one result per call: the last motor command of the call
//   (kind, speed, steering), the PID-clear pulse, the done flag and the phase.
//   The APB port holds eight registers at byte addresses 0x00..0x1C; write
//   them only while no call is in flight. Reads return the current values.
// Pipeline and throughput:
//   A call lands in the input register at its transfer edge; once the result
//   register is free it is evaluated against the phase state and the result is
//   loaded into the result register. While drive does not stall, one call per
//   cycle is taken; the phase register is updated in the same cycle as the result.
// Reset:
//   Registers return to their defaults, the phase to normal, the phase start
//   time to zero, and both pipeline registers empty.
// Stall:
//   While drive is not ready the result holds; one more call can wait in the
//   input register, after which sensor.ready drops until drive takes a result.
module obstacle_bypass_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    obsq_sensor_if.sink sensor,
    obsq_drive_if.source drive,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import obsq_pkg::*;

    obsq_cfg_t          cfg_reg;
    obsq_cfg_t          cfg_next;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    logic               in_valid_reg;
    logic [31:0]        in_now_reg;
    logic signed [11:0] in_pos_reg;

    logic               out_valid_reg;
    obsq_result_t       out_reg;

    logic [2:0]         phase_reg;
    logic [31:0]        start_ms_reg;

    obsq_result_t       step_result;
    logic               step_start_load;
    logic               advance;
    logic               eval;

    // Configuration write decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DRIVE_SPEED:    cfg_next.drive_speed_set   = pwdata[9:0];
                REG_STEER_AMOUNT:   cfg_next.steer_amount      = pwdata[10:0];
                REG_SEARCH_STEER:   cfg_next.search_steer      = pwdata[10:0];
                REG_CENTER_TOL:     cfg_next.center_tolerance  = pwdata[10:0];
                REG_SEARCH_WINDOW:  cfg_next.search_window     = pwdata[10:0];
                REG_REJOIN_TOL:     cfg_next.rejoin_tolerance  = pwdata[10:0];
                REG_CENTER_TIMEOUT: cfg_next.center_timeout_ms = pwdata[15:0];
                REG_SEARCH_TIMEOUT: cfg_next.search_timeout_ms = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_speed_set   <= 10'd600;
            cfg_reg.steer_amount      <= 11'd1750;
            cfg_reg.search_steer      <= 11'd1200;
            cfg_reg.center_tolerance  <= 11'd200;
            cfg_reg.search_window     <= 11'd1700;
            cfg_reg.rejoin_tolerance  <= 11'd500;
            cfg_reg.center_timeout_ms <= 16'd1000;
            cfg_reg.search_timeout_ms <= 16'd3000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register readback
    always_comb
    begin
        case (cfg_idx)
            REG_DRIVE_SPEED:    prdata = {22'd0, cfg_reg.drive_speed_set};
            REG_STEER_AMOUNT:   prdata = {21'd0, cfg_reg.steer_amount};
            REG_SEARCH_STEER:   prdata = {21'd0, cfg_reg.search_steer};
            REG_CENTER_TOL:     prdata = {21'd0, cfg_reg.center_tolerance};
            REG_SEARCH_WINDOW:  prdata = {21'd0, cfg_reg.search_window};
            REG_REJOIN_TOL:     prdata = {21'd0, cfg_reg.rejoin_tolerance};
            REG_CENTER_TIMEOUT: prdata = {16'd0, cfg_reg.center_timeout_ms};
            REG_SEARCH_TIMEOUT: prdata = {16'd0, cfg_reg.search_timeout_ms};
            default:            prdata = '0;
        endcase
    end

    // Pipeline flow: result register frees when empty or taken
    assign advance      = !out_valid_reg || drive.ready;
    assign eval         = in_valid_reg && advance;
    assign sensor.ready = !in_valid_reg || advance;

    // Hold the accepted call
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sensor.ready)
        begin
            in_valid_reg <= sensor.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sensor.valid && sensor.ready)
        begin
            in_now_reg <= sensor.now_ms;
            in_pos_reg <= sensor.bar_pos;
        end
    end

    obsq_step u_step (
        .cfg        (cfg_reg),
        .phase_cur  (phase_reg),
        .start_ms   (start_ms_reg),
        .now_ms     (in_now_reg),
        .bar_pos    (in_pos_reg),
        .result     (step_result),
        .start_load (step_start_load)
    );

    // Advance the phase state with each evaluated call
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NORMAL;
            start_ms_reg <= '0;
        end
        else if (eval)
        begin
            phase_reg <= step_result.phase;
            if (step_start_load)
            begin
                start_ms_reg <= in_now_reg;
            end
        end
    end

    // Load and hold the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval)
        begin
            out_reg <= step_result;
        end
    end

    assign drive.valid         = out_valid_reg;
    assign drive.command_kind  = out_reg.command_kind;
    assign drive.speed         = out_reg.speed;
    assign drive.steering      = out_reg.steering;
    assign drive.clear_pid     = out_reg.clear_pid;
    assign drive.maneuver_done = out_reg.maneuver_done;
    assign drive.phase         = out_reg.phase;

    // A finished maneuver always reports normal phase and a PID clear
    a_done_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.maneuver_done) |->
            (out_reg.phase == PH_NORMAL && out_reg.clear_pid))
        else $error("done result without normal phase or PID clear");

    // Normal phase always moves on to centring
    a_normal_to_center: assert property (@(posedge clk) disable iff (!rst_n)
        (eval && phase_reg == PH_NORMAL) |=> (phase_reg == PH_CENTER))
        else $error("normal phase did not advance to centring");

    // A return to normal keeps the stored phase start
    a_start_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (eval && step_result.phase == PH_NORMAL) |=> $stable(start_ms_reg))
        else $error("phase start changed on return to normal");

    // A waiting call is not dropped while the result register is blocked
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending call lost during stall");

    // Phase state only moves when a call is evaluated
    a_phase_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !eval |=> $stable(phase_reg))
        else $error("phase changed without an evaluated call");

endmodule
